### sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define EPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define EPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### sv/epp_pkg.sv
// ----------------------------------------------------------------------------
// epp_pkg: shared definitions of the EEG packet parser
// Framing constants, the stage-1 item type and the decoded result type.
// ----------------------------------------------------------------------------
package epp_pkg;

	localparam logic [7:0] SYNC_BYTE    = 8'hAA;
	localparam logic [7:0] RAW_CODE     = 8'h04;
	localparam logic [7:0] SUMMARY_CODE = 8'h20;
	localparam logic [7:0] RAW_TAG      = 8'h80;
	localparam logic [7:0] SUMMARY_TAG  = 8'h02;

	localparam int RAW_LEN     = 5;
	localparam int SUMMARY_LEN = 33;
	localparam int COUNT_W     = $clog2(SUMMARY_LEN);
	localparam int BAND_COUNT  = 8;

	localparam logic KIND_RAW     = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef logic [7:0]  byte_t;
	typedef logic [23:0] power_t;

	// One received byte held in the input register.
	typedef struct packed {
		logic  valid;
		byte_t rx_byte;
		logic  sink_ready;
	} rx_item_t;

	// One decoded frame.
	typedef struct packed {
		logic        kind;
		logic [15:0] level;
		power_t      delta_power;
		power_t      theta_power;
		power_t      low_alpha_power;
		power_t      high_alpha_power;
		power_t      low_beta_power;
		power_t      high_beta_power;
		power_t      low_gamma_power;
		power_t      mid_gamma_power;
		byte_t       attention;
		byte_t       meditation;
	} res_t;

endpackage

### sv/epp_rx_if.sv
// ----------------------------------------------------------------------------
// epp_rx_if: received byte channel
// Valid/ready channel carrying one serial byte and the sink-ready flag.
// ----------------------------------------------------------------------------
interface epp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       sink_ready;

	modport source (output valid, output rx_byte, output sink_ready, input ready);
	modport sink (input valid, input rx_byte, input sink_ready, output ready);
endinterface

### sv/epp_res_if.sv
// ----------------------------------------------------------------------------
// epp_res_if: decoded result channel
// Valid/ready channel carrying one decoded raw or summary frame.
// ----------------------------------------------------------------------------
interface epp_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] level;
	logic [23:0] delta_power;
	logic [23:0] theta_power;
	logic [23:0] low_alpha_power;
	logic [23:0] high_alpha_power;
	logic [23:0] low_beta_power;
	logic [23:0] high_beta_power;
	logic [23:0] low_gamma_power;
	logic [23:0] mid_gamma_power;
	logic [7:0]  attention;
	logic [7:0]  meditation;

	modport source (
		output valid, output kind, output level,
		output delta_power, output theta_power,
		output low_alpha_power, output high_alpha_power,
		output low_beta_power, output high_beta_power,
		output low_gamma_power, output mid_gamma_power,
		output attention, output meditation,
		input ready
	);
	modport sink (
		input valid, input kind, input level,
		input delta_power, input theta_power,
		input low_alpha_power, input high_alpha_power,
		input low_beta_power, input high_beta_power,
		input low_gamma_power, input mid_gamma_power,
		input attention, input meditation,
		output ready
	);
endinterface

### sv/epp_rx_stage.sv
// ----------------------------------------------------------------------------
// epp_rx_stage: input register
// Captures one received byte per transaction and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module epp_rx_stage (
	input  logic              clk,
	input  logic              arst_n,
	epp_rx_if.sink            rx,
	input  logic              take,
	output epp_pkg::rx_item_t item
);

	logic          valid_s1;
	epp_pkg::byte_t byte_s1;
	logic          ready_s1;

	// The register frees up in the same cycle that the parser consumes it.
	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1  <= rx.rx_byte;
			ready_s1 <= rx.sink_ready;
		end
	end

	assign item.valid      = valid_s1;
	assign item.rx_byte    = byte_s1;
	assign item.sink_ready = ready_s1;

endmodule

### sv/epp_parser.sv
// ----------------------------------------------------------------------------
// epp_parser: framing state machine, frame store and decoder
// Advances the sync/frame state on each consumed byte, stores frame bytes and
// decodes a completed frame together with its final byte.
// ----------------------------------------------------------------------------
module epp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  epp_pkg::rx_item_t item,
	input  logic              take,
	output logic              res_valid,
	output epp_pkg::res_t     res_data
);

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_SYNC1,
		ST_SYNC2,
		ST_RAW,
		ST_SUMM
	} state_t;

	state_t                        state_q;
	logic [epp_pkg::COUNT_W-1:0]   count_q;
	logic [epp_pkg::COUNT_W-1:0]   count_nxt;
	logic [epp_pkg::COUNT_W-1:0]   limit;
	epp_pkg::byte_t                frame_q [epp_pkg::SUMMARY_LEN];
	epp_pkg::byte_t                cur     [epp_pkg::SUMMARY_LEN];
	logic                          in_frame;
	logic                          done;
	logic                          opening;
	epp_pkg::byte_t                tag;
	epp_pkg::power_t               bands   [epp_pkg::BAND_COUNT];

	assign in_frame  = (state_q == ST_RAW) || (state_q == ST_SUMM);
	assign limit     = (state_q == ST_RAW) ? epp_pkg::COUNT_W'(epp_pkg::RAW_LEN)
	                                       : epp_pkg::COUNT_W'(epp_pkg::SUMMARY_LEN);
	assign count_nxt = count_q + 1'b1;
	assign done      = in_frame && (count_nxt == limit);
	assign opening   = (state_q == ST_SYNC2) &&
	                   ((item.rx_byte == epp_pkg::RAW_CODE) ||
	                    (item.rx_byte == epp_pkg::SUMMARY_CODE));

	// The frame as it stands once the current byte is written in.
	always_comb begin
		for (int k = 0; k < epp_pkg::SUMMARY_LEN; k++) begin
			cur[k] = (in_frame && (count_q == epp_pkg::COUNT_W'(k))) ? item.rx_byte
			                                                        : frame_q[k];
		end
	end

	assign tag = cur[0];

	assign res_valid = item.valid && done && item.sink_ready &&
	                   ((tag == epp_pkg::RAW_TAG) || (tag == epp_pkg::SUMMARY_TAG));

	always_comb begin
		for (int j = 0; j < epp_pkg::BAND_COUNT; j++) begin
			bands[j] = {cur[4 + 3 * j], cur[5 + 3 * j], cur[6 + 3 * j]};
		end
	end

	always_comb begin
		res_data = '0;
		if (tag == epp_pkg::SUMMARY_TAG) begin
			res_data.kind             = epp_pkg::KIND_SUMMARY;
			res_data.level            = {8'h00, cur[1]};
			res_data.delta_power      = bands[0];
			res_data.theta_power      = bands[1];
			res_data.low_alpha_power  = bands[2];
			res_data.high_alpha_power = bands[3];
			res_data.low_beta_power   = bands[4];
			res_data.high_beta_power  = bands[5];
			res_data.low_gamma_power  = bands[6];
			res_data.mid_gamma_power  = bands[7];
			res_data.attention        = cur[29];
			res_data.meditation       = cur[31];
		end else begin
			res_data.kind  = epp_pkg::KIND_RAW;
			res_data.level = {cur[2], cur[3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			count_q <= '0;
		end else if (take) begin
			case (state_q)
				ST_SYNC1: begin
					state_q <= (item.rx_byte == epp_pkg::SYNC_BYTE) ? ST_SYNC2 : ST_HUNT;
				end
				ST_SYNC2: begin
					if (item.rx_byte == epp_pkg::RAW_CODE) begin
						state_q <= ST_RAW;
					end else if (item.rx_byte == epp_pkg::SUMMARY_CODE) begin
						state_q <= ST_SUMM;
					end else begin
						state_q <= ST_HUNT;
					end
					count_q <= '0;
				end
				ST_RAW, ST_SUMM: begin
					if (done) begin
						state_q <= ST_HUNT;
						count_q <= '0;
					end else begin
						count_q <= count_nxt;
					end
				end
				default: begin
					state_q <= (item.rx_byte == epp_pkg::SYNC_BYTE) ? ST_SYNC1 : ST_HUNT;
				end
			endcase
		end
	end

	// Opening a frame wipes the store, so a short frame decoded as a summary
	// reads zeros past its last byte.
	always_ff @(posedge clk) begin
		if (take) begin
			for (int k = 0; k < epp_pkg::SUMMARY_LEN; k++) begin
				if (opening) begin
					frame_q[k] <= '0;
				end else if (in_frame && (count_q == epp_pkg::COUNT_W'(k))) begin
					frame_q[k] <= item.rx_byte;
				end
			end
		end
	end

endmodule

### sv/epp_res_stage.sv
// ----------------------------------------------------------------------------
// epp_res_stage: result register
// Holds one decoded frame on the result channel until it is taken.
// ----------------------------------------------------------------------------
module epp_res_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  epp_pkg::res_t res_data,
	output logic          free,
	epp_res_if.source     res
);

	logic          valid_q;
	epp_pkg::res_t data_q;

	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= res_data;
		end
	end

	assign res.valid            = valid_q;
	assign res.kind             = data_q.kind;
	assign res.level            = data_q.level;
	assign res.delta_power      = data_q.delta_power;
	assign res.theta_power      = data_q.theta_power;
	assign res.low_alpha_power  = data_q.low_alpha_power;
	assign res.high_alpha_power = data_q.high_alpha_power;
	assign res.low_beta_power   = data_q.low_beta_power;
	assign res.high_beta_power  = data_q.high_beta_power;
	assign res.low_gamma_power  = data_q.low_gamma_power;
	assign res.mid_gamma_power  = data_q.mid_gamma_power;
	assign res.attention        = data_q.attention;
	assign res.meditation       = data_q.meditation;

endmodule

### sv/eeg_packet_parser.sv
// A result shows on res once the last frame byte has passed the input register and then the result register.
// Throughput: one byte per cycle, set by the input register feeding the parser and result register.
// A byte stalls only while a completed frame waits behind an untaken result.
// Reset: the parser returns to hunting for sync with an empty byte count, and both registers empty.
// The frame store has no reset; it is cleared each time a frame opens.
// ----------------------------------------------------------------------------
// eeg_packet_parser: serial packet parser for a brainwave headset stream
// Finds sync bytes, collects raw and summary frames and decodes them.
// ----------------------------------------------------------------------------
module eeg_packet_parser (
	input  logic      clk,
	input  logic      arst_n,
	epp_rx_if.sink    rx,
	epp_res_if.source res
);

	epp_pkg::rx_item_t item;
	epp_pkg::res_t     res_data;
	logic              res_valid;
	logic              free;
	logic              take;

	// A byte moves on unless it completes a frame with a result and the result register is full and not taken.
	assign take = item.valid && (!res_valid || free);

	epp_rx_stage u_rx_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.take   (take),
		.item   (item)
	);

	epp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.take      (take),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	epp_res_stage u_res_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take && res_valid),
		.res_data (res_data),
		.free     (free),
		.res      (res)
	);

endmodule

### sv/epp_checker.sv
// ----------------------------------------------------------------------------
// epp_checker: port-level checks of the EEG packet parser
// Watches the result channel for handshake and decode consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_kind,
	input logic [15:0] res_level,
	input logic [23:0] res_delta_power,
	input logic [23:0] res_mid_gamma_power,
	input logic [7:0]  res_attention,
	input logic [7:0]  res_meditation
);

	// A stalled result keeps its valid and its level.
	`EPP_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_level))

	// A raw sample carries nothing in the summary fields.
	`EPP_ASSERT_IMP(a_raw_clean, clk, arst_n, res_valid && (res_kind == epp_pkg::KIND_RAW), (res_delta_power == '0) && (res_mid_gamma_power == '0) && (res_attention == '0) && (res_meditation == '0))

	// Signal quality is a single byte.
	`EPP_ASSERT_IMP(a_quality_byte, clk, arst_n, res_valid && (res_kind == epp_pkg::KIND_SUMMARY), res_level[15:8] == 8'h00)

endmodule

bind eeg_packet_parser epp_checker u_epp_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.res_valid           (res.valid),
	.res_ready           (res.ready),
	.res_kind            (res.kind),
	.res_level           (res.level),
	.res_delta_power     (res.delta_power),
	.res_mid_gamma_power (res.mid_gamma_power),
	.res_attention       (res.attention),
	.res_meditation      (res.meditation)
);
